// File: hdl/vfa_pkg.sv
// types, constants and helpers shared by the vector alu pipeline
package vfa_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PROD_BITS  = 2 * WORD_BITS;
	localparam int SUM_BITS   = PROD_BITS + 2;
	localparam int NUM_MULS   = 6;
	localparam int LANES      = 3;
	localparam int ROOT_STEPS = WORD_BITS;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int DIV_STEPS  = QUO_BITS;
	localparam int DIVD_BITS  = WORD_BITS + FRAC_BITS;

	typedef logic signed [WORD_BITS-1:0] word_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_SCALE,
		OP_NEG,
		OP_DOT,
		OP_CROSS,
		OP_LEN,
		OP_NORM
	} op_t;

	typedef struct packed {
		op_t   opcode;
		word_t a_x;
		word_t a_y;
		word_t a_z;
		word_t b_x;
		word_t b_y;
		word_t b_z;
		word_t scale_factor;
	} req_t;

	typedef struct packed {
		word_t r_x;
		word_t r_y;
		word_t r_z;
		word_t r_scalar;
		logic  error_flag;
	} rsp_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
	} vec_t;

	typedef struct packed {
		op_t   opcode;
		vec_t  vec;
		word_t scalar;
	} carry_t;

	function automatic word_t sat_word(input logic signed [SUM_BITS-1:0] v);
		logic [SUM_BITS-WORD_BITS:0] upper;
		upper = v[SUM_BITS-1:WORD_BITS-1];
		if ((&upper) || !(|upper)) begin
			return v[WORD_BITS-1:0];
		end else if (v[SUM_BITS-1]) begin
			return WORD_MIN;
		end else begin
			return WORD_MAX;
		end
	endfunction

endpackage

// File: hdl/vec3_fixed_point_alu.sv
// top level of the q16.16 3d vector alu
// every opcode passes through the same stages from request to result
// (3 front stages, 32 square root stages, 17 divider stages, 1 output register)
// throughput: one request per cycle; a held result stalls the whole pipeline in place
// reset clears the stage valid bits only, the datapath registers are not reset
module vec3_fixed_point_alu (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  vfa_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output vfa_pkg::rsp_t rsp_data
);
	import vfa_pkg::*;

	logic                 en;
	logic                 valid_s3;
	carry_t               carry_s3;
	logic [PROD_BITS-1:0] sq_s3;

	// pipeline advances unless a result is held at the output
	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;

	vfa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req_valid),
		.req      (req_data),
		.valid_s3 (valid_s3),
		.carry_s3 (carry_s3),
		.sq_s3    (sq_s3)
	);

	vfa_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.carry     (carry_s3),
		.sq        (sq_s3),
		.out_valid (rsp_valid),
		.rsp       (rsp_data)
	);

endmodule

// File: hdl/vfa_front.sv
// front stages: operand select and products, sums, rounding and saturation
module vfa_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  vfa_pkg::req_t                  req,
	output logic                           valid_s3,
	output vfa_pkg::carry_t                carry_s3,
	output logic [vfa_pkg::PROD_BITS-1:0]  sq_s3
);
	import vfa_pkg::*;

	word_t                       pa [NUM_MULS];
	word_t                       pb [NUM_MULS];
	vec_t                        vec_d;
	logic                        valid_s1;
	op_t                         op_s1;
	vec_t                        vec_s1;
	logic signed [PROD_BITS-1:0] prod_s1 [NUM_MULS];
	logic signed [SUM_BITS-1:0]  t_d [LANES];
	logic signed [SUM_BITS-1:0]  tsc_d;
	logic                        valid_s2;
	op_t                         op_s2;
	vec_t                        vec_s2;
	logic signed [SUM_BITS-1:0]  t_s2 [LANES];
	logic signed [SUM_BITS-1:0]  tsc_s2;
	carry_t                      carry_d;

	// operand select
	always_comb begin
		pa = '{req.a_y, req.a_z, req.a_z, req.a_x, req.a_x, req.a_y};
		pb = '{req.b_z, req.b_y, req.b_x, req.b_z, req.b_y, req.b_x};
		vec_d = '0;
		case (req.opcode)
			OP_ADD: begin
				vec_d.x = sat_word(SUM_BITS'(req.a_x) + SUM_BITS'(req.b_x));
				vec_d.y = sat_word(SUM_BITS'(req.a_y) + SUM_BITS'(req.b_y));
				vec_d.z = sat_word(SUM_BITS'(req.a_z) + SUM_BITS'(req.b_z));
			end
			OP_SUB: begin
				vec_d.x = sat_word(SUM_BITS'(req.a_x) - SUM_BITS'(req.b_x));
				vec_d.y = sat_word(SUM_BITS'(req.a_y) - SUM_BITS'(req.b_y));
				vec_d.z = sat_word(SUM_BITS'(req.a_z) - SUM_BITS'(req.b_z));
			end
			OP_NEG: begin
				vec_d.x = sat_word(-SUM_BITS'(req.a_x));
				vec_d.y = sat_word(-SUM_BITS'(req.a_y));
				vec_d.z = sat_word(-SUM_BITS'(req.a_z));
			end
			OP_SCALE: begin
				pa[0] = req.a_x;
				pa[1] = req.a_y;
				pa[2] = req.a_z;
				pb[0] = req.scale_factor;
				pb[1] = req.scale_factor;
				pb[2] = req.scale_factor;
			end
			OP_DOT: begin
				pa[0] = req.a_x;
				pa[1] = req.a_y;
				pa[2] = req.a_z;
				pb[0] = req.b_x;
				pb[1] = req.b_y;
				pb[2] = req.b_z;
			end
			OP_LEN, OP_NORM: begin
				pa[0] = req.a_x;
				pa[1] = req.a_y;
				pa[2] = req.a_z;
				pb[0] = req.a_x;
				pb[1] = req.a_y;
				pb[2] = req.a_z;
				if (req.opcode == OP_NORM) begin
					vec_d.x = req.a_x;
					vec_d.y = req.a_y;
					vec_d.z = req.a_z;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= req.opcode;
			vec_s1 <= vec_d;
			for (int i = 0; i < NUM_MULS; i++) begin
				prod_s1[i] <= pa[i] * pb[i];
			end
		end
	end

	// stage 2: exact sums
	always_comb begin
		if (op_s1 == OP_CROSS) begin
			t_d[0] = SUM_BITS'(prod_s1[0]) - SUM_BITS'(prod_s1[1]);
			t_d[1] = SUM_BITS'(prod_s1[2]) - SUM_BITS'(prod_s1[3]);
			t_d[2] = SUM_BITS'(prod_s1[4]) - SUM_BITS'(prod_s1[5]);
		end else begin
			t_d[0] = SUM_BITS'(prod_s1[0]);
			t_d[1] = SUM_BITS'(prod_s1[1]);
			t_d[2] = SUM_BITS'(prod_s1[2]);
		end
		tsc_d = SUM_BITS'(prod_s1[0]) + SUM_BITS'(prod_s1[1]) + SUM_BITS'(prod_s1[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			vec_s2 <= vec_s1;
			tsc_s2 <= tsc_d;
			for (int i = 0; i < LANES; i++) begin
				t_s2[i] <= t_d[i];
			end
		end
	end

	// stage 3: floor shift and saturate
	always_comb begin
		carry_d.opcode = op_s2;
		carry_d.vec    = vec_s2;
		carry_d.scalar = '0;
		case (op_s2)
			OP_SCALE, OP_CROSS: begin
				carry_d.vec.x = sat_word(t_s2[0] >>> FRAC_BITS);
				carry_d.vec.y = sat_word(t_s2[1] >>> FRAC_BITS);
				carry_d.vec.z = sat_word(t_s2[2] >>> FRAC_BITS);
			end
			OP_DOT: begin
				carry_d.scalar = sat_word(tsc_s2 >>> FRAC_BITS);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s3 <= carry_d;
			sq_s3    <= tsc_s2[PROD_BITS-1:0];
		end
	end

endmodule

// File: hdl/vfa_norm.sv
// square root and division stages for length and normalise, plus output register
module vfa_norm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  vfa_pkg::carry_t               carry,
	input  logic [vfa_pkg::PROD_BITS-1:0] sq,
	output logic                          out_valid,
	output vfa_pkg::rsp_t                 rsp
);
	import vfa_pkg::*;

	typedef struct packed {
		carry_t                             c;
		logic [WORD_BITS-1:0]               len;
		logic [LANES-1:0]                   neg;
		logic [LANES-1:0][DIVD_BITS-1:0]    rem;
		logic [LANES-1:0][QUO_BITS-1:0]     quo;
	} div_t;

	logic                 rt_v_s [ROOT_STEPS+1];
	carry_t               rt_c_s [ROOT_STEPS+1];
	logic [PROD_BITS-1:0] rt_n_s [ROOT_STEPS+1];
	logic [PROD_BITS-1:0] rt_root_s [ROOT_STEPS+1];
	logic                 dv_v_s [DIV_STEPS+1];
	div_t                 dv_s [DIV_STEPS+1];
	word_t                lane [LANES];
	logic [WORD_BITS-1:0] mag [LANES];
	div_t                 fin;
	rsp_t                 rsp_d;
	logic [WORD_BITS-1:0] qw [LANES];
	word_t                rv [LANES];
	rsp_t                 rsp_q;
	logic                 valid_q;

	assign rt_v_s[0]    = in_valid;
	assign rt_c_s[0]    = carry;
	assign rt_n_s[0]    = sq;
	assign rt_root_s[0] = '0;

	// one root bit per stage
	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam logic [PROD_BITS-1:0] BIT_K = PROD_BITS'(1) << (PROD_BITS - 2 - 2 * k);
		logic [PROD_BITS-1:0] trial;

		assign trial = rt_root_s[k] + BIT_K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else if (en) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_c_s[k+1] <= rt_c_s[k];
				if (rt_n_s[k] >= trial) begin
					rt_n_s[k+1]    <= rt_n_s[k] - trial;
					rt_root_s[k+1] <= (rt_root_s[k] >> 1) + BIT_K;
				end else begin
					rt_n_s[k+1]    <= rt_n_s[k];
					rt_root_s[k+1] <= rt_root_s[k] >> 1;
				end
			end
		end
	end

	// divider entry: magnitudes scaled up by the fraction width
	always_comb begin
		lane = '{rt_c_s[ROOT_STEPS].vec.x, rt_c_s[ROOT_STEPS].vec.y,
			rt_c_s[ROOT_STEPS].vec.z};
		dv_s[0].c   = rt_c_s[ROOT_STEPS];
		dv_s[0].len = rt_root_s[ROOT_STEPS][WORD_BITS-1:0];
		dv_s[0].quo = '0;
		for (int l = 0; l < LANES; l++) begin
			dv_s[0].neg[l] = lane[l][WORD_BITS-1];
			mag[l]         = lane[l][WORD_BITS-1] ? -lane[l] : lane[l];
			dv_s[0].rem[l] = {mag[l], {FRAC_BITS{1'b0}}};
		end
	end
	assign dv_v_s[0] = rt_v_s[ROOT_STEPS];

	// one quotient bit per stage, all lanes in parallel
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int SH = DIV_STEPS - 1 - j;
		logic [DIVD_BITS-1:0] dsub;
		div_t                 nxt;

		always_comb begin
			dsub = DIVD_BITS'(dv_s[j].len) << SH;
			nxt  = dv_s[j];
			for (int l = 0; l < LANES; l++) begin
				if (dv_s[j].rem[l] >= dsub) begin
					nxt.rem[l] = dv_s[j].rem[l] - dsub;
					nxt.quo[l] = {dv_s[j].quo[l][QUO_BITS-2:0], 1'b1};
				end else begin
					nxt.quo[l] = {dv_s[j].quo[l][QUO_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j+1] <= nxt;
			end
		end
	end

	// result select
	always_comb begin
		fin = dv_s[DIV_STEPS];
		for (int l = 0; l < LANES; l++) begin
			qw[l] = {{(WORD_BITS-QUO_BITS){1'b0}}, fin.quo[l]};
			rv[l] = fin.neg[l] ? -qw[l] : qw[l];
		end
		rsp_d.r_x        = fin.c.vec.x;
		rsp_d.r_y        = fin.c.vec.y;
		rsp_d.r_z        = fin.c.vec.z;
		rsp_d.r_scalar   = fin.c.scalar;
		rsp_d.error_flag = 1'b0;
		case (fin.c.opcode)
			OP_LEN: begin
				rsp_d.r_scalar = fin.len[WORD_BITS-1] ? WORD_MAX : fin.len;
			end
			OP_NORM: begin
				if (fin.len == '0) begin
					rsp_d.r_x        = '0;
					rsp_d.r_y        = '0;
					rsp_d.r_z        = '0;
					rsp_d.error_flag = 1'b1;
				end else begin
					rsp_d.r_x = rv[0];
					rsp_d.r_y = rv[1];
					rsp_d.r_z = rv[2];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv_v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= rsp_d;
		end
	end

	assign out_valid = valid_q;
	assign rsp       = rsp_q;

endmodule
